/* rtl/core/tsom_pkg.sv */
// types, codes and constants shared by the timestamp option marker
package tsom_pkg;

   localparam int AREA_W               = 6;
   localparam int MAX_OPTION_BYTES_DEF = 40;

   // walk phases
   localparam logic [1:0] PH_KIND = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   // option kinds and limits
   localparam logic [7:0] KIND_EOL    = 8'd0;
   localparam logic [7:0] KIND_NOP    = 8'd1;
   localparam logic [7:0] KIND_TS     = 8'd8;
   localparam logic [7:0] MIN_OPT_LEN = 8'd2;
   localparam logic [AREA_W-1:0] TS_ROOM = AREA_W'(10);

   // timestamp byte offsets
   localparam logic [3:0] TS_VAL_FIRST = 4'd2;
   localparam logic [3:0] TS_VAL_LAST  = 4'd5;
   localparam logic [3:0] TS_ECR_FIRST = 4'd6;
   localparam logic [3:0] TS_ECR_LAST  = 4'd9;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic [AREA_W-1:0] area_len;
      logic              first;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       ts_rewritten;
      logic       bad_length;
   } rsp_type;

endpackage

/* rtl/core/tcp_timestamp_option_marker_unit.sv */
// top level of the tcp timestamp option marker
// Walks the TCP option area one byte per request and passes every byte on,
// setting bit 0 of the last byte of tsval and of tsecr when that value is
// nonzero in the first timestamp option that fits in the area; the walk
// stops there, at an EOL, or at an option length below 2 (flagged as
// bad_length on the last byte). One request is taken every cycle while the
// unit has room, and each response passes through two registers: the
// request register, then the walker into the response register. Throughput
// is set by the walker state, which is updated once per byte; a stalled
// response register stalls the request register behind it, and the
// request side keeps taking bytes as long as one of the two has room.
module tcp_timestamp_option_marker_unit
   import tsom_pkg::*;
#(
   parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // request register
   logic    req_valid_ff;
   req_type req_payload_ff;
   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_payload_ff;

   rsp_type walk_result;
   logic    advance;

   // move a byte through the walker when the response slot is free or leaving
   assign advance   = req_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~req_valid_ff | advance;

   tsom_walker #(
      .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (req_payload_ff),
      .result(walk_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_payload_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= walk_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/core/tsom_walker.sv */
// option walk state and per-byte rewrite logic
module tsom_walker
   import tsom_pkg::*;
#(
   parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   logic [1:0]        phase_ff, phase_cur, phase_in;
   logic [AREA_W-1:0] area_ff, area_cur, area_in, area_start;
   logic [7:0]        opt_ff, opt_cur, opt_in, opt_dec;
   logic [3:0]        pos_ff, pos_cur, pos_in;
   logic              vnz_ff, vnz_cur, vnz_in;
   logic              enz_ff, enz_cur, enz_in;
   logic              seen_ff, seen_cur, seen_in;
   logic              fault_ff, fault_cur, fault_in;
   logic [7:0]        b, o;
   logic              last;

   assign b = item.data_byte;

   // saturate the area length, zero taken as one
   always_comb begin
      if (item.area_len > AREA_W'(MAX_OPTION_BYTES)) begin
         area_start = AREA_W'(MAX_OPTION_BYTES);
      end else if (item.area_len == '0) begin
         area_start = AREA_W'(1);
      end else begin
         area_start = item.area_len;
      end
   end

   // state seen by this byte: fresh on the first byte of a segment
   always_comb begin
      if (item.first) begin
         phase_cur = PH_KIND;
         area_cur  = area_start;
         opt_cur   = '0;
         pos_cur   = '0;
         vnz_cur   = 1'b0;
         enz_cur   = 1'b0;
         seen_cur  = 1'b0;
         fault_cur = 1'b0;
      end else begin
         phase_cur = phase_ff;
         area_cur  = area_ff;
         opt_cur   = opt_ff;
         pos_cur   = pos_ff;
         vnz_cur   = vnz_ff;
         enz_cur   = enz_ff;
         seen_cur  = seen_ff;
         fault_cur = fault_ff;
      end
   end

   assign opt_dec = (opt_cur != '0) ? opt_cur - 8'd1 : '0;

   always_comb begin
      phase_in = phase_cur;
      area_in  = area_cur;
      opt_in   = opt_cur;
      pos_in   = pos_cur;
      vnz_in   = vnz_cur;
      enz_in   = enz_cur;
      seen_in  = seen_cur;
      fault_in = fault_cur;
      o        = b;
      last     = 1'b0;
      if (area_cur != '0) begin
         last    = (area_cur == AREA_W'(1));
         area_in = area_cur - AREA_W'(1);
         unique case (phase_cur)
            PH_KIND: begin
               if (b == KIND_EOL) begin
                  phase_in = PH_DONE;
               end else if (b == KIND_NOP) begin
                  phase_in = PH_KIND;
               end else if (b == KIND_TS && area_cur >= TS_ROOM) begin
                  seen_in  = 1'b1;
                  pos_in   = 4'd1;
                  vnz_in   = 1'b0;
                  enz_in   = 1'b0;
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (b < MIN_OPT_LEN) begin
                  fault_in = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  opt_in   = b - MIN_OPT_LEN;
                  phase_in = (b == MIN_OPT_LEN) ? PH_KIND : PH_BODY;
               end
            end
            PH_BODY: begin
               if (pos_cur != '0) begin
                  if (pos_cur >= TS_VAL_FIRST && pos_cur <= TS_VAL_LAST) begin
                     vnz_in = vnz_cur | (b != '0);
                     if (pos_cur == TS_VAL_LAST && vnz_in) begin
                        o = b | 8'd1;
                     end
                  end else if (pos_cur >= TS_ECR_FIRST && pos_cur <= TS_ECR_LAST) begin
                     enz_in = enz_cur | (b != '0);
                     if (pos_cur == TS_ECR_LAST && enz_in) begin
                        o = b | 8'd1;
                     end
                  end
                  if (pos_cur >= TS_ECR_LAST) begin
                     pos_in   = '0;
                     phase_in = PH_DONE;
                  end else begin
                     pos_in = pos_cur + 4'd1;
                  end
               end else begin
                  opt_in = opt_dec;
                  if (opt_dec == '0) begin
                     phase_in = PH_KIND;
                  end
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign result.out_byte     = o;
   assign result.out_last     = last;
   assign result.ts_rewritten = last & seen_in;
   assign result.bad_length   = last & fault_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KIND;
         area_ff  <= '0;
         opt_ff   <= '0;
         pos_ff   <= '0;
         vnz_ff   <= 1'b0;
         enz_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         fault_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         area_ff  <= area_in;
         opt_ff   <= opt_in;
         pos_ff   <= pos_in;
         vnz_ff   <= vnz_in;
         enz_ff   <= enz_in;
         seen_ff  <= seen_in;
         fault_ff <= fault_in;
      end
   end

endmodule

/* rtl/core/tsom_checker.sv */
// port-level checks for the timestamp option marker, bound to the top level
module tsom_checker
   import tsom_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // segment flags only on the final byte
   a_flags_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.ts_rewritten || rsp_payload.bad_length)
         |-> rsp_payload.out_last)
      else $error("segment flag outside the last byte");

   // a segment is never flagged both as a timestamp and as a bad length
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.ts_rewritten && rsp_payload.bad_length))
      else $error("timestamp and bad length on one segment");

   // an empty pipeline never refuses a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!req_valid) && !$past(reset) |-> req_ready)
      else $error("request refused with pipeline empty");

endmodule

bind tcp_timestamp_option_marker_unit tsom_checker u_tsom_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);

/* dv/tb.sv */
// self-checking testbench for the tcp timestamp option marker unit
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsom_pkg::*;

   localparam int MAX_AREA       = MAX_OPTION_BYTES_DEF;
   localparam int AREA_FIELD_MAX = (1 << AREA_W) - 1;
   localparam int RANDOM_BYTES   = 1300;
   localparam int DRAIN_EVERY    = 400;
   localparam int LONG_HOLD      = 150;
   localparam int LONG_HOLD_AT   = 600;
   localparam int IDLE_LIMIT     = 2000;
   localparam int MISMATCH_SHOWN = 10;

   // one request waiting to be driven; a set flag holds it back until the
   // unit has returned everything that is owed
   typedef struct {
      req_type req;
      bit      wait_for_drain;
   } option_byte_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   tcp_timestamp_option_marker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5ns clock = ~clock;

   option_byte_type pending_bytes[$];
   rsp_type         expected_out_bytes[$];

   // walker state of the predictor
   logic [1:0]        walk_phase    = PH_KIND;
   logic [AREA_W-1:0] area_left     = '0;
   logic [7:0]        option_left   = '0;
   logic [3:0]        ts_position   = '0;
   bit                tsval_nonzero = 1'b0;
   bit                tsecr_nonzero = 1'b0;
   bit                ts_seen       = 1'b0;
   bit                length_fault  = 1'b0;

   // bookkeeping
   int      requests_taken   = 0;
   int      responses_taken  = 0;
   int      segments_started = 0;
   int      stray_bytes      = 0;
   int      ts_marked        = 0;
   int      bad_walks        = 0;
   int      mismatch_count   = 0;
   int      cycle_count      = 0;
   int      idle_cycles      = 0;
   int      send_gap         = 0;
   int      hold_left        = 0;
   int      stall_pick       = 0;
   bit      long_hold_done   = 1'b0;
   rsp_type want_rsp;
   string   bad_fields;

   // predicted response for one request; updates the walker state
   function automatic rsp_type mark_option_byte(req_type r);
      rsp_type    o;
      logic [7:0] b;
      int         n;
      bit         last;
      b = r.data_byte;
      o = '0;
      o.out_byte = b;
      // a set first always opens a fresh segment, even in the middle of one
      if (r.first) begin
         n = r.area_len;
         if (n > MAX_AREA) n = MAX_AREA;
         if (n == 0) n = 1;
         area_left     = AREA_W'(n);
         walk_phase    = PH_KIND;
         option_left   = '0;
         ts_position   = '0;
         tsval_nonzero = 1'b0;
         tsecr_nonzero = 1'b0;
         ts_seen       = 1'b0;
         length_fault  = 1'b0;
         segments_started++;
      end
      // no open segment: the byte goes through untouched, flags low
      if (area_left == 0) begin
         stray_bytes++;
         return o;
      end
      last = (area_left == 1);
      case (walk_phase)
         PH_KIND: begin
            if (b == KIND_EOL) begin
               walk_phase = PH_DONE;
            end else if (b == KIND_NOP) begin
               walk_phase = PH_KIND;
            end else if (b == KIND_TS && area_left >= TS_ROOM) begin
               // timestamp with room: its length byte is skipped unchecked
               ts_seen       = 1'b1;
               ts_position   = 4'd1;
               tsval_nonzero = 1'b0;
               tsecr_nonzero = 1'b0;
               walk_phase    = PH_BODY;
            end else begin
               walk_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            if (b < MIN_OPT_LEN) begin
               length_fault = 1'b1;
               walk_phase   = PH_DONE;
            end else begin
               option_left = b - MIN_OPT_LEN;
               walk_phase  = (option_left == 0) ? PH_KIND : PH_BODY;
            end
         end
         PH_BODY: begin
            if (ts_position != 0) begin
               if (ts_position >= TS_VAL_FIRST && ts_position <= TS_VAL_LAST) begin
                  if (b != 0) tsval_nonzero = 1'b1;
                  if (ts_position == TS_VAL_LAST && tsval_nonzero) o.out_byte = b | 8'h01;
               end else if (ts_position >= TS_ECR_FIRST && ts_position <= TS_ECR_LAST) begin
                  if (b != 0) tsecr_nonzero = 1'b1;
                  if (ts_position == TS_ECR_LAST && tsecr_nonzero) o.out_byte = b | 8'h01;
               end
               // the walk ends with the timestamp
               if (ts_position >= TS_ECR_LAST) begin
                  ts_position = '0;
                  walk_phase  = PH_DONE;
               end else begin
                  ts_position = ts_position + 4'd1;
               end
            end else begin
               if (option_left > 0) option_left = option_left - 8'd1;
               if (option_left == 0) walk_phase = PH_KIND;
            end
         end
         default: begin
         end
      endcase
      area_left      = area_left - AREA_W'(1);
      o.out_last     = last;
      o.ts_rewritten = last && ts_seen;
      o.bad_length   = last && length_fault;
      if (o.ts_rewritten) ts_marked++;
      if (o.bad_length) bad_walks++;
      return o;
   endfunction

   // idle length for either side: mostly none, some short, a few long
   function automatic int pick_idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // windows in which neither side idles
   function automatic bit quiet_stretch();
      return ((cycle_count / 400) % 5) == 4;
   endfunction

   // four value bytes: all zero, one nonzero byte, or fully random
   function automatic void add_ts_value(ref logic [7:0] seg[$]);
      int mode;
      int spot;
      mode = $urandom_range(0, 2);
      spot = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         if (mode == 0) seg.push_back(8'h00);
         else if (mode == 1) seg.push_back(i == spot ? 8'($urandom_range(1, 255)) : 8'h00);
         else seg.push_back(8'($urandom));
      end
   endfunction

   // well-formed option area of n bytes; the last option may overrun it
   function automatic void build_options(int n, ref logic [7:0] seg[$]);
      int room;
      int roll;
      int olen;
      seg.delete();
      while (seg.size() < n) begin
         room = n - seg.size();
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            seg.push_back(KIND_NOP);
         end else if (roll < 50 && room >= TS_ROOM) begin
            seg.push_back(KIND_TS);
            // length byte is not looked at, so it is sometimes garbage
            seg.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'(TS_ROOM));
            add_ts_value(seg);
            add_ts_value(seg);
         end else if (roll < 55) begin
            seg.push_back(KIND_EOL);
            while (seg.size() < n) seg.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
         end else begin
            seg.push_back(8'($urandom_range(2, 255)));
            olen = $urandom_range(2, room < 12 ? room + 2 : 12);
            seg.push_back(8'(olen));
            for (int i = 2; i < olen; i++) seg.push_back(8'($urandom));
         end
      end
      while (seg.size() > n) void'(seg.pop_back());
   endfunction

   // area that ends in a short length or a timestamp kind with no room
   function automatic void build_broken(int n, ref logic [7:0] seg[$]);
      int         stop;
      logic [7:0] kind;
      seg.delete();
      if ($urandom_range(0, 1)) begin
         stop = $urandom_range(0, n - 2);
         while (seg.size() < stop) seg.push_back(KIND_NOP);
         kind = 8'($urandom_range(2, 255));
         if (kind == KIND_TS) kind = KIND_TS + 8'd1;
         seg.push_back(kind);
         seg.push_back(8'($urandom_range(0, 1)));
      end else begin
         stop = n - $urandom_range(1, n < 9 ? n : 9);
         while (seg.size() < stop) seg.push_back(KIND_NOP);
         seg.push_back(KIND_TS);
      end
      while (seg.size() < n) seg.push_back(8'($urandom));
   endfunction

   // queue the first keep bytes of seg; opens marks the first one as a start
   function automatic void queue_segment(logic [7:0] seg[$], logic [AREA_W-1:0] len_field,
                                         int keep, bit opens, bit drain);
      option_byte_type item;
      for (int i = 0; i < keep && i < seg.size(); i++) begin
         item.req.data_byte  = seg[i];
         item.req.area_len   = len_field;
         item.req.first      = opens && (i == 0);
         item.wait_for_drain = drain && (i == 0);
         pending_bytes.push_back(item);
      end
   endfunction

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN)
         $display({"mismatch at %0t: %s; expected byte %02h last %b ts %b bad %b,",
                   " got byte %02h last %b ts %b bad %b"},
                  $time, what, want.out_byte, want.out_last, want.ts_rewritten, want.bad_length,
                  got.out_byte, got.out_last, got.ts_rewritten, got.bad_length);
   endfunction

   // stimulus, reset and end of run
   initial begin : stimulus
      logic [7:0]        seg[$];
      logic [AREA_W-1:0] len_field;
      int                n;
      int                keep;
      int                roll;
      int                fed;
      bit                drain;

      // directed: nop then a timestamp whose length byte is zero, tsval nonzero
      // only in its top byte (low byte gets marked), tsecr all zero (untouched)
      seg = '{KIND_NOP, KIND_TS, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00};
      queue_segment(seg, AREA_W'(11), seg.size(), 1'b1, 1'b0);
      // zero area length is taken as one byte
      seg = '{8'hff};
      queue_segment(seg, '0, 1, 1'b1, 1'b0);
      // byte after the area has ended, with every area length bit set
      seg = '{KIND_TS};
      queue_segment(seg, AREA_W'(AREA_FIELD_MAX), 1, 1'b0, 1'b0);
      // option length of one stops the walk and flags it
      seg = '{8'hfe, 8'h01, 8'h55};
      queue_segment(seg, AREA_W'(3), 3, 1'b1, 1'b0);
      // oversized area cut short by a new segment: timestamp kind without
      // room, then a zero length
      seg = '{KIND_EOL, 8'h7f};
      queue_segment(seg, AREA_W'(AREA_FIELD_MAX), 2, 1'b1, 1'b0);
      seg = '{KIND_TS, 8'h00};
      queue_segment(seg, AREA_W'(2), 2, 1'b1, 1'b0);

      // random segments, mostly well formed; the first one waits for a drain
      fed   = 0;
      drain = 1'b1;
      while (fed < RANDOM_BYTES) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : $urandom_range(10, MAX_AREA);
            build_options(n, seg);
            keep      = n;
            len_field = AREA_W'(n);
         end else if (roll < 70) begin
            // noise
            n = $urandom_range(1, MAX_AREA);
            seg.delete();
            repeat (n) seg.push_back(8'($urandom));
            keep      = n;
            len_field = AREA_W'(n);
         end else if (roll < 80) begin
            n = $urandom_range(2, MAX_AREA);
            build_broken(n, seg);
            keep      = n;
            len_field = AREA_W'(n);
         end else if (roll < 88) begin
            // cut off by the next segment's first byte
            n = $urandom_range(10, MAX_AREA);
            build_options(n, seg);
            keep      = $urandom_range(1, n - 1);
            len_field = AREA_W'(n);
         end else begin
            // area length field outside the legal range
            if ($urandom_range(0, 2) == 0) begin
               n         = 1;
               len_field = '0;
            end else begin
               n         = MAX_AREA;
               len_field = AREA_W'($urandom_range(MAX_AREA + 1, AREA_FIELD_MAX));
            end
            build_options(n, seg);
            keep = n;
         end
         queue_segment(seg, len_field, keep, 1'b1, drain);
         fed  += keep;
         drain = (fed / DRAIN_EVERY) != ((fed - keep) / DRAIN_EVERY);
         // now and then a few bytes turn up with no segment open
         if (keep == n && $urandom_range(0, 9) == 0) begin
            seg.delete();
            repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom));
            queue_segment(seg, AREA_W'($urandom), seg.size(), 1'b0, 1'b0);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all requests taken, then all responses back, then a short tail;
      // checked between edges where the driver's updates have settled
      while (pending_bytes.size() != 0 || req_valid) @(negedge clock);
      while (expected_out_bytes.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("summary: %0d requests in %0d segments, %0d bytes outside any segment",
               requests_taken, segments_started, stray_bytes);
      $display("summary: %0d timestamp rewrites, %0d bad-length walks, %0d mismatches",
               ts_marked, bad_walks, mismatch_count);
      if (mismatch_count == 0 && expected_out_bytes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // driver: predicts each accepted request, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_out_bytes.push_back(mark_option_byte(req_payload));
            requests_taken++;
         end
         // payload may only change once the current request is gone
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].wait_for_drain && expected_out_bytes.size() != 0)) begin
               req_payload <= pending_bytes[0].req;
               void'(pending_bytes.pop_front());
               req_valid <= 1'b1;
               send_gap = quiet_stretch() ? 0 : pick_idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold that backs up the unit
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && responses_taken >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (quiet_stretch()) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_pick = pick_idle_length();
         if (stall_pick == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            hold_left = stall_pick - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   // monitor: each response against the oldest prediction, field by field
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_taken++;
         if (expected_out_bytes.size() == 0) begin
            report_mismatch("response with nothing expected", '0, rsp_payload);
         end else begin
            want_rsp   = expected_out_bytes.pop_front();
            bad_fields = "";
            if (rsp_payload.out_byte !== want_rsp.out_byte) bad_fields = {bad_fields, " out_byte"};
            if (rsp_payload.out_last !== want_rsp.out_last) bad_fields = {bad_fields, " out_last"};
            if (rsp_payload.ts_rewritten !== want_rsp.ts_rewritten)
               bad_fields = {bad_fields, " ts_rewritten"};
            if (rsp_payload.bad_length !== want_rsp.bad_length)
               bad_fields = {bad_fields, " bad_length"};
            if (bad_fields.len() != 0)
               report_mismatch({"wrong", bad_fields}, want_rsp, rsp_payload);
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      cycle_count++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses still owed",
                  idle_cycles, expected_out_bytes.size());
         $display("tb: failure");
         $finish;
      end
   end

endmodule
